// ===== hw/rtl/hash_table_insert_quadratic_probe_defines.svh =====
// assertion macros shared by the hash insert checker
// no dependencies; expects aclk and aresetn in the scope of each use
`ifndef HASH_TABLE_INSERT_QUADRATIC_PROBE_DEFINES_SVH
`define HASH_TABLE_INSERT_QUADRATIC_PROBE_DEFINES_SVH

// checked only while out of reset
`define HTIQP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define HTIQP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/htiqp_pkg.sv =====
// types, constants and microcode rom of the hash table insert block
// no dependencies
`default_nettype none

package htiqp_pkg;

    localparam int unsigned MIX_SHIFT = 33;
    localparam logic [31:0] MIX_MUL_A = 32'hff51afd7;
    localparam logic [31:0] MIX_MUL_B = 32'hc4ceb9fe;
    localparam int unsigned LOAD_NUM  = 10;
    localparam int unsigned LOAD_DEN  = 7;

    localparam int unsigned CFG_W       = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;
    localparam int unsigned COUNT_W     = 11;
    localparam int unsigned SLOT_OUT_W  = 10;
    localparam int unsigned STEP_OUT_W  = 10;
    localparam int unsigned HASH_W      = 64;
    localparam int unsigned IN_W        = 128;
    localparam int unsigned OUT_W       = 96;

    // result item layout, lowest bit first
    localparam int unsigned OUT_STATUS_LSB  = 0;
    localparam int unsigned OUT_SLOT_LSB    = 1;
    localparam int unsigned OUT_HASH_LSB    = 11;
    localparam int unsigned OUT_STEPS_LSB   = 75;
    localparam int unsigned OUT_ENTRIES_LSB = 85;

    typedef logic [3:0] pc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_WAIT_IN,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_START,
        OP_READ,
        OP_CHECK,
        OP_DROP,
        OP_STORE,
        OP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_CLEAR_BUSY,
        COND_NO_INPUT,
        COND_OVER_LOAD,
        COND_SLOT_FREE,
        COND_MORE_PROBES,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t  op;
        logic  mul_b;
        cond_t cond_a;
        pc_t   tgt_a;
        cond_t cond_b;
        pc_t   tgt_b;
    } ucode_t;

    localparam pc_t PC_CLEAR = 4'd0;
    localparam pc_t PC_IDLE  = 4'd1;
    localparam pc_t PC_MLO_A = 4'd2;
    localparam pc_t PC_MHI_A = 4'd3;
    localparam pc_t PC_MLO_B = 4'd4;
    localparam pc_t PC_MHI_B = 4'd5;
    localparam pc_t PC_START = 4'd6;
    localparam pc_t PC_READ  = 4'd7;
    localparam pc_t PC_CHECK = 4'd8;
    localparam pc_t PC_DROP  = 4'd9;
    localparam pc_t PC_EMIT  = 4'd10;
    localparam pc_t PC_STORE = 4'd11;

    // branch a is tried first, then branch b, else fall through to pc + 1
    function automatic ucode_t ucode_rom(pc_t pc);
        ucode_t w;
        w = '{OP_NOP, 1'b0, COND_ALWAYS, PC_IDLE, COND_NEVER, PC_IDLE};
        case (pc)
            PC_CLEAR: w = '{OP_CLEAR,   1'b0, COND_CLEAR_BUSY,  PC_CLEAR, COND_NEVER,  PC_IDLE};
            PC_IDLE:  w = '{OP_WAIT_IN, 1'b0, COND_NO_INPUT,    PC_IDLE,  COND_NEVER,  PC_IDLE};
            PC_MLO_A: w = '{OP_MUL_LO,  1'b0, COND_NEVER,       PC_IDLE,  COND_NEVER,  PC_IDLE};
            PC_MHI_A: w = '{OP_MUL_HI,  1'b0, COND_NEVER,       PC_IDLE,  COND_NEVER,  PC_IDLE};
            PC_MLO_B: w = '{OP_MUL_LO,  1'b1, COND_NEVER,       PC_IDLE,  COND_NEVER,  PC_IDLE};
            PC_MHI_B: w = '{OP_MUL_HI,  1'b1, COND_NEVER,       PC_IDLE,  COND_NEVER,  PC_IDLE};
            PC_START: w = '{OP_START,   1'b0, COND_OVER_LOAD,   PC_DROP,  COND_NEVER,  PC_IDLE};
            PC_READ:  w = '{OP_READ,    1'b0, COND_NEVER,       PC_IDLE,  COND_NEVER,  PC_IDLE};
            PC_CHECK: w = '{OP_CHECK,   1'b0, COND_SLOT_FREE,   PC_STORE,
                            COND_MORE_PROBES, PC_READ};
            PC_DROP:  w = '{OP_DROP,    1'b0, COND_NEVER,       PC_IDLE,  COND_NEVER,  PC_IDLE};
            PC_EMIT:  w = '{OP_EMIT,    1'b0, COND_OUT_BUSY,    PC_EMIT,  COND_ALWAYS, PC_IDLE};
            PC_STORE: w = '{OP_STORE,   1'b0, COND_ALWAYS,      PC_EMIT,  COND_NEVER,  PC_IDLE};
            default:  w = '{OP_NOP,     1'b0, COND_ALWAYS,      PC_IDLE,  COND_NEVER,  PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hash_table_insert_quadratic_probe.sv =====
// hash table insert with triangular probing, run by a microcoded sequencer; uses htiqp_pkg
// an accepted item is mixed by multiply rounds with MIX_MUL_A and MIX_MUL_B, then probed
// after a load-limit check, with one registered read of the used-flag memory per probe
// a new item is accepted only after the last result is placed in the output register
// reset: synchronous, active low; afterwards a clearing pass walks every entry of the
// used-flag memory, and no item is accepted until it ends
`default_nettype none

module hash_table_insert_quadratic_probe #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [htiqp_pkg::CFG_W-1:0]   cfg_wr_data,   // capacity_log2
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [htiqp_pkg::IN_W-1:0]    s_tdata,       // insert_key, insert_value
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status, slot_index, key_hash, probe_steps, entries_held
    output logic [htiqp_pkg::OUT_W-1:0]        m_tdata
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CAP_W   = IDX_W + 1;
    localparam int LG_MAX  = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int GUARD_W = (IDX_W + 4 > 15) ? IDX_W + 4 : 15;
    localparam logic [4:0] LG_MAX_V = 5'(LG_MAX);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    htiqp_pkg::ucode_t uc;

    htiqp_pkg::pc_t pc_reg, pc_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CAP_W-1:0] step_reg, step_next;
    logic [htiqp_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [htiqp_pkg::CFG_W-1:0] cap_log2_reg, cap_log2_next;
    logic status_reg, status_next;
    logic [63:0] key_reg, key_next;
    logic [63:0] val_reg, val_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] prod_reg, prod_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [htiqp_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic used_mem [TABLE_DEPTH];
    logic [191:0] entry_mem [TABLE_DEPTH];
    logic used_rd_reg;

    logic [4:0] lg_eff;
    logic [CAP_W-1:0] cap;
    logic [IDX_W-1:0] mask;
    logic [GUARD_W-1:0] load_now, load_lim;
    logic [31:0] mul_const;
    logic [31:0] mul_hi;
    logic [63:0] mix_sum;
    logic [CAP_W-1:0] step_inc;
    logic out_busy;
    logic cond_a_hit, cond_b_hit;

    function automatic logic cond_eval(htiqp_pkg::cond_t c, logic clear_busy, logic no_in,
                                       logic over, logic free, logic more, logic busy);
        logic r;
        case (c)
            htiqp_pkg::COND_NEVER:       r = 1'b0;
            htiqp_pkg::COND_ALWAYS:      r = 1'b1;
            htiqp_pkg::COND_CLEAR_BUSY:  r = clear_busy;
            htiqp_pkg::COND_NO_INPUT:    r = no_in;
            htiqp_pkg::COND_OVER_LOAD:   r = over;
            htiqp_pkg::COND_SLOT_FREE:   r = free;
            htiqp_pkg::COND_MORE_PROBES: r = more;
            htiqp_pkg::COND_OUT_BUSY:    r = busy;
            default:                     r = 1'b0;
        endcase
        return r;
    endfunction

    assign uc       = htiqp_pkg::ucode_rom(pc_reg);
    assign s_tready = (uc.op == htiqp_pkg::OP_WAIT_IN);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_busy = m_tvalid_reg && !m_tready;

    // zero reads as one slot pair, saturate at the largest power of two in the table
    always_comb begin
        lg_eff = {1'b0, cap_log2_reg};
        if (lg_eff == 5'd0) begin
            lg_eff = 5'd1;
        end
        if (lg_eff > LG_MAX_V) begin
            lg_eff = LG_MAX_V;
        end
    end

    assign cap       = CAP_W'(1) << lg_eff;
    assign mask      = IDX_W'(cap - 1'b1);
    assign load_now  = GUARD_W'(count_reg) * GUARD_W'(htiqp_pkg::LOAD_NUM);
    assign load_lim  = GUARD_W'(cap) * GUARD_W'(htiqp_pkg::LOAD_DEN);
    assign mul_const = uc.mul_b ? htiqp_pkg::MIX_MUL_B : htiqp_pkg::MIX_MUL_A;
    assign mul_hi    = x_reg[63:32] * mul_const;
    assign mix_sum   = prod_reg + {mul_hi, 32'd0};
    assign step_inc  = step_reg + 1'b1;

    assign cond_a_hit = cond_eval(uc.cond_a, idx_reg != IDX_LAST, !s_tvalid,
                                  load_now >= load_lim, !used_rd_reg, step_inc != cap,
                                  out_busy);
    assign cond_b_hit = cond_eval(uc.cond_b, idx_reg != IDX_LAST, !s_tvalid,
                                  load_now >= load_lim, !used_rd_reg, step_inc != cap,
                                  out_busy);

    always_comb begin
        idx_next      = idx_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        x_next        = x_reg;
        prod_next     = prod_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        cap_log2_next = cfg_wr_en ? cfg_wr_data : cap_log2_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (uc.op)
            htiqp_pkg::OP_CLEAR: begin
                idx_next = idx_reg + 1'b1;
            end
            htiqp_pkg::OP_WAIT_IN: begin
                if (s_tvalid) begin
                    key_next = s_tdata[63:0];
                    val_next = s_tdata[127:64];
                    x_next   = s_tdata[63:0] ^ (s_tdata[63:0] >> htiqp_pkg::MIX_SHIFT);
                end
            end
            htiqp_pkg::OP_MUL_LO: begin
                prod_next = 64'(x_reg[31:0]) * 64'(mul_const);
            end
            htiqp_pkg::OP_MUL_HI: begin
                x_next = mix_sum ^ (mix_sum >> htiqp_pkg::MIX_SHIFT);
            end
            htiqp_pkg::OP_START: begin
                idx_next    = x_reg[IDX_W-1:0] & mask;
                step_next   = '0;
                status_next = 1'b0;
            end
            htiqp_pkg::OP_READ: begin
                idx_next = idx_reg;
            end
            htiqp_pkg::OP_CHECK: begin
                if (used_rd_reg) begin
                    step_next = step_inc;
                    idx_next  = (idx_reg + IDX_W'(step_inc)) & mask;
                end
            end
            htiqp_pkg::OP_DROP: begin
                status_next = 1'b1;
            end
            htiqp_pkg::OP_STORE: begin
                count_next = count_reg + 1'b1;
            end
            htiqp_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {count_reg,
                                     status_reg ? htiqp_pkg::STEP_OUT_W'(0)
                                                : htiqp_pkg::STEP_OUT_W'(step_reg),
                                     x_reg,
                                     status_reg ? htiqp_pkg::SLOT_OUT_W'(0)
                                                : htiqp_pkg::SLOT_OUT_W'(idx_reg),
                                     status_reg};
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase

        if (cond_a_hit) begin
            pc_next = uc.tgt_a;
        end else if (cond_b_hit) begin
            pc_next = uc.tgt_b;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= htiqp_pkg::PC_CLEAR;
            idx_reg      <= '0;
            count_reg    <= '0;
            cap_log2_reg <= htiqp_pkg::CFG_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            cap_log2_reg <= cap_log2_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        step_reg    <= step_next;
        status_reg  <= status_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        x_reg       <= x_next;
        prod_reg    <= prod_next;
        m_tdata_reg <= m_tdata_next;
    end

    // used flags: swept clear after reset, set on store, registered read taken unconditionally and used once per probe
    always_ff @(posedge aclk) begin
        if (uc.op == htiqp_pkg::OP_CLEAR) begin
            used_mem[idx_reg] <= 1'b0;
        end else if (uc.op == htiqp_pkg::OP_STORE) begin
            used_mem[idx_reg] <= 1'b1;
        end
        used_rd_reg <= used_mem[idx_reg];
    end

    // stored entry: hash, value, key
    always_ff @(posedge aclk) begin
        if (uc.op == htiqp_pkg::OP_STORE) begin
            entry_mem[idx_reg] <= {x_reg, val_reg, key_reg};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/htiqp_checker.sv =====
// port-level checks for the hash table insert block, bound to its top level
// depends on htiqp_pkg and hash_table_insert_quadratic_probe_defines.svh
`default_nettype none
`include "hash_table_insert_quadratic_probe_defines.svh"

module htiqp_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [htiqp_pkg::OUT_W-1:0]  m_tdata
);

    logic                           res_status;
    logic [htiqp_pkg::SLOT_OUT_W-1:0] res_slot;
    logic [htiqp_pkg::STEP_OUT_W-1:0] res_steps;
    logic [htiqp_pkg::COUNT_W-1:0]  res_entries;
    logic [htiqp_pkg::COUNT_W-1:0]  last_entries_reg;

    assign res_status  = m_tdata[htiqp_pkg::OUT_STATUS_LSB];
    assign res_slot    = m_tdata[htiqp_pkg::OUT_SLOT_LSB +: htiqp_pkg::SLOT_OUT_W];
    assign res_steps   = m_tdata[htiqp_pkg::OUT_STEPS_LSB +: htiqp_pkg::STEP_OUT_W];
    assign res_entries = m_tdata[htiqp_pkg::OUT_ENTRIES_LSB +: htiqp_pkg::COUNT_W];

    // entry count carried by the last delivered item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_entries_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            last_entries_reg <= res_entries;
        end
    end

    `HTIQP_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid && !s_tready, "busy after reset")
    `HTIQP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result moved while stalled")
    `HTIQP_ASSERT(a_drop_zero, m_tvalid && res_status |-> res_slot == '0 && res_steps == '0, "dropped item with slot or steps")
    `HTIQP_ASSERT(a_count_track, m_tvalid && m_tready |-> res_entries == last_entries_reg + htiqp_pkg::COUNT_W'(!res_status), "entry count out of step")

endmodule

bind hash_table_insert_quadratic_probe htiqp_checker u_htiqp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
